### design/pmle_pkg.sv
// Shared types, constants and helpers of the polynomial motion law evaluator.
package pmle_pkg;

  // Q16.16 fraction width and the width of the Horner and scaling datapath.
  localparam int FRAC_W = 16;
  localparam int ACC_W  = 48;

  // Scaling divider: magnitude width (clip bound is 2^(MAG_W-1)), one quotient bit per stage.
  localparam int MAG_W     = 45;
  localparam int DIV_STEPS = MAG_W;
  localparam int DIV_LAT   = DIV_STEPS + 2;

  // Time normalization divider: one stage for the clamp, then one quotient bit per stage.
  localparam int U_STEPS = FRAC_W;
  localparam int U_W     = FRAC_W + 1;

  // Horner steps for a six-coefficient polynomial.
  localparam int H_STEPS = 5;

  // Pipeline registers ahead of the output register.
  localparam int NV = 1 + U_STEPS + H_STEPS + 3 * DIV_LAT;

  // Register indexes of the configuration port.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LAW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_V0    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_V1    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A0    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_A1    = 3'd5;

  localparam logic [31:0] DUR_RESET = 32'h0001_0000;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef acc_t [5:0] poly_t;

  // Coefficients of position and its three derivatives, index = power of u.
  typedef struct packed {
    poly_t pos;
    poly_t vel;
    poly_t acc;
    poly_t jrk;
  } coef_t;

  typedef struct packed {
    logic               law;
    logic signed [31:0] v0;
    logic signed [31:0] v1;
    logic signed [31:0] a0;
    logic signed [31:0] a1;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

### design/polynomial_motion_law_eval_unit.sv
// Top level of the cubic/quintic polynomial motion law evaluator.
//
//   channel  direction  handshake                  payload
//   in       sink       in_valid_i / in_ready_o    sample_time_i
//   out      source     out_valid_o / out_ready_i  position_o, velocity_o, acceleration_o, jerk_o
//   cfg      sink       cfg_we_i (no wait)         cfg_idx_i, cfg_wdata_i
//
// One item per clock while the skid register is empty; an item passes through the 17-stage time divider,
// five Horner stages and three 47-stage scaling dividers before the output register.
// Coefficients settle through the pmle_coef register stages after a register write, well before an item needs them.
// Reset clears the registers to their defaults and empties the pipeline.
// A skid register behind the output register absorbs one item; the pipeline holds while it is full.
module polynomial_motion_law_eval_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [31:0]                        sample_time_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [31:0]                 position_o,
  output logic signed [31:0]                 velocity_o,
  output logic signed [31:0]                 acceleration_o,
  output logic signed [31:0]                 jerk_o,
  input  logic                               cfg_we_i,
  input  logic [pmle_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [31:0]                        cfg_wdata_i
);
  import pmle_pkg::*;

  function automatic acc_t hstep(input acc_t a, input logic [U_W-1:0] u, input acc_t k);
    logic signed [ACC_W+U_W:0] p;
    p = a * $signed({1'b0, u});
    return $signed(p[ACC_W+FRAC_W-1:FRAC_W]) + k;
  endfunction

  // Configuration registers.
  logic        law_q;
  logic [31:0] dur_q, v0_q, v1_q, a0_q, a1_q;
  logic [31:0] d;
  cfg_t        cfg;
  coef_t       coef;

  logic        adv;
  logic        ge0;
  logic [NV-1:0] valid_q;

  logic [31:0]    urem_q [U_STEPS+1];
  logic [U_W-1:0] uq_q   [U_STEPS+1];
  logic [32:0]    urem2  [U_STEPS];
  logic           uge    [U_STEPS];

  acc_t           kk     [4][6];
  acc_t           hacc_q [4][H_STEPS];
  logic [U_W-1:0] hu_q   [H_STEPS-1];

  acc_t dv1_o, da1_o, da2_o, dj1_o, dj2_o, dj3_o;

  logic signed [31:0] pos_dl_q [3*DIV_LAT];
  logic signed [31:0] vel_dl_q [2*DIV_LAT];
  logic signed [31:0] acc_dl_q [DIV_LAT];

  logic [127:0] fin, out_q, sk_q;
  logic         out_v_q, sk_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      law_q <= 1'b0;
      dur_q <= DUR_RESET;
      v0_q  <= '0;
      v1_q  <= '0;
      a0_q  <= '0;
      a1_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LAW: law_q <= cfg_wdata_i[0];
        REG_DUR: dur_q <= cfg_wdata_i;
        REG_V0:  v0_q  <= cfg_wdata_i;
        REG_V1:  v1_q  <= cfg_wdata_i;
        REG_A0:  a0_q  <= cfg_wdata_i;
        REG_A1:  a1_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A zero duration behaves as the smallest nonzero one.
  assign d = (dur_q == '0) ? 32'd1 : dur_q;

  assign cfg.law = law_q;
  assign cfg.v0  = v0_q;
  assign cfg.v1  = v1_q;
  assign cfg.a0  = a0_q;
  assign cfg.a1  = a1_q;

  pmle_coef u_coef (
    .clk_i  (clk_i),
    .cfg_i  (cfg),
    .d_i    (d),
    .coef_o (coef)
  );

  assign adv        = !sk_v_q;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[NV-2:0], in_valid_i};
    end
  end

  // Time normalization: clamp folds into the first quotient bit, then restoring steps.
  assign ge0 = sample_time_i >= d;

  always_comb begin
    for (int s = 0; s < U_STEPS; s++) begin
      urem2[s] = {urem_q[s], 1'b0};
      uge[s]   = urem2[s] >= {1'b0, d};
    end
  end

  always_comb begin
    for (int p = 0; p < 6; p++) begin
      kk[0][p] = coef.pos[p];
      kk[1][p] = coef.vel[p];
      kk[2][p] = coef.acc[p];
      kk[3][p] = coef.jrk[p];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      uq_q[0]   <= {{(U_W-1){1'b0}}, ge0};
      urem_q[0] <= ge0 ? '0 : sample_time_i;
      for (int s = 0; s < U_STEPS; s++) begin
        urem_q[s+1] <= uge[s] ? 32'(urem2[s] - {1'b0, d}) : urem2[s][31:0];
        uq_q[s+1]   <= {uq_q[s][U_W-2:0], uge[s]};
      end
      // Each of the four polynomials runs its own six-term Horner pipe on the shared u; shorter ones lead with zeros.
      for (int p = 0; p < 4; p++) begin
        hacc_q[p][0] <= hstep(kk[p][5], uq_q[U_STEPS], kk[p][4]);
        for (int s = 1; s < H_STEPS; s++) begin
          hacc_q[p][s] <= hstep(hacc_q[p][s-1], hu_q[s-1], kk[p][4-s]);
        end
      end
      hu_q[0] <= uq_q[U_STEPS];
      for (int s = 1; s < H_STEPS-1; s++) begin
        hu_q[s] <= hu_q[s-1];
      end
    end
  end

  pmle_sdiv u_div_v1 (.clk_i(clk_i), .en_i(adv), .d_i(d), .r_i(hacc_q[1][H_STEPS-1]), .r_o(dv1_o));
  pmle_sdiv u_div_a1 (.clk_i(clk_i), .en_i(adv), .d_i(d), .r_i(hacc_q[2][H_STEPS-1]), .r_o(da1_o));
  pmle_sdiv u_div_a2 (.clk_i(clk_i), .en_i(adv), .d_i(d), .r_i(da1_o), .r_o(da2_o));
  pmle_sdiv u_div_j1 (.clk_i(clk_i), .en_i(adv), .d_i(d), .r_i(hacc_q[3][H_STEPS-1]), .r_o(dj1_o));
  pmle_sdiv u_div_j2 (.clk_i(clk_i), .en_i(adv), .d_i(d), .r_i(dj1_o), .r_o(dj2_o));
  pmle_sdiv u_div_j3 (.clk_i(clk_i), .en_i(adv), .d_i(d), .r_i(dj2_o), .r_o(dj3_o));

  // Results that need fewer divisions wait in delay lines for the jerk path.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos_dl_q[0] <= sat32(64'(hacc_q[0][H_STEPS-1]));
      vel_dl_q[0] <= sat32(64'(dv1_o));
      acc_dl_q[0] <= sat32(64'(da2_o));
      for (int i = 1; i < 3*DIV_LAT; i++) begin
        pos_dl_q[i] <= pos_dl_q[i-1];
      end
      for (int i = 1; i < 2*DIV_LAT; i++) begin
        vel_dl_q[i] <= vel_dl_q[i-1];
      end
      for (int i = 1; i < DIV_LAT; i++) begin
        acc_dl_q[i] <= acc_dl_q[i-1];
      end
    end
  end

  assign fin = {pos_dl_q[3*DIV_LAT-1], vel_dl_q[2*DIV_LAT-1], acc_dl_q[DIV_LAT-1],
                sat32(64'(dj3_o))};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else if (adv) begin
      if (out_v_q && !out_ready_i) begin
        sk_v_q <= valid_q[NV-1];
      end else begin
        out_v_q <= valid_q[NV-1];
      end
    end else if (out_ready_i) begin
      out_v_q <= 1'b1;
      sk_v_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (out_v_q && !out_ready_i) begin
        sk_q <= fin;
      end else begin
        out_q <= fin;
      end
    end else if (out_ready_i) begin
      out_q <= sk_q;
    end
  end

  assign out_valid_o    = out_v_q;
  assign position_o     = out_q[127:96];
  assign velocity_o     = out_q[95:64];
  assign acceleration_o = out_q[63:32];
  assign jerk_o         = out_q[31:0];

endmodule

### design/pmle_coef.sv
// Law coefficients derived from the boundary registers, settled over six register stages.
module pmle_coef (
  input  logic           clk_i,
  input  pmle_pkg::cfg_t cfg_i,
  input  logic [31:0]    d_i,
  output pmle_pkg::coef_t coef_o
);
  import pmle_pkg::*;

  localparam acc_t Q2  = acc_t'(2 * 65536);
  localparam acc_t Q3  = acc_t'(3 * 65536);
  localparam acc_t Q6  = acc_t'(6 * 65536);
  localparam acc_t Q10 = acc_t'(10 * 65536);
  localparam acc_t Q15 = acc_t'(15 * 65536);

  logic signed [64:0] pv0_q, pv1_q, pa0_q, pa1_q, pb0_q, pb1_q;
  logic signed [64:0] pv0_d, pv1_d, pa0_d, pa1_d, pb0_d, pb1_d;
  logic signed [32:0] dd;
  logic signed [31:0] v0_q, v1_q, ah0_q, ah1_q, a0_q, a1_q;
  acc_t ev0, ev1, ea0, ea1, h0, h1, t0;
  acc_t c1_d, c2_d, c3_d, c4_d, c5_d;
  acc_t c1_q, c2_q, c3_q, c4_q, c5_q;
  coef_t coef_d, coef_q;

  assign dd    = $signed({1'b0, d_i});
  assign pv0_d = $signed(cfg_i.v0) * dd;
  assign pv1_d = $signed(cfg_i.v1) * dd;
  assign pa0_d = $signed(cfg_i.a0) * dd;
  assign pa1_d = $signed(cfg_i.a1) * dd;
  assign pb0_d = ah0_q * dd;
  assign pb1_d = ah1_q * dd;

  always_comb begin
    ev0 = acc_t'(v0_q);
    ev1 = acc_t'(v1_q);
    ea0 = acc_t'(a0_q);
    ea1 = acc_t'(a1_q);
    h0  = ea0 >>> 1;
    h1  = ea1 >>> 1;
    t0  = (ea0 + (ea0 <<< 1)) >>> 1;
    c1_d = ev0;
    if (cfg_i.law) begin
      c2_d = h0;
      c3_d = Q10 - 48'sd6 * ev0 - t0 - 48'sd4 * ev1 + h1;
      c4_d = -Q15 + 48'sd8 * ev0 + t0 + 48'sd7 * ev1 - ea1;
      c5_d = Q6 - 48'sd3 * ev0 - h0 - 48'sd3 * ev1 + h1;
    end else begin
      c2_d = Q3 - 48'sd2 * ev0 - ev1;
      c3_d = ev0 + ev1 - Q2;
      c4_d = '0;
      c5_d = '0;
    end
  end

  always_comb begin
    coef_d.pos[0] = '0;
    coef_d.pos[1] = c1_q;
    coef_d.pos[2] = c2_q;
    coef_d.pos[3] = c3_q;
    coef_d.pos[4] = c4_q;
    coef_d.pos[5] = c5_q;
    coef_d.vel[0] = c1_q;
    coef_d.vel[1] = 48'sd2 * c2_q;
    coef_d.vel[2] = 48'sd3 * c3_q;
    coef_d.vel[3] = 48'sd4 * c4_q;
    coef_d.vel[4] = 48'sd5 * c5_q;
    coef_d.vel[5] = '0;
    coef_d.acc[0] = 48'sd2 * c2_q;
    coef_d.acc[1] = 48'sd6 * c3_q;
    coef_d.acc[2] = 48'sd12 * c4_q;
    coef_d.acc[3] = 48'sd20 * c5_q;
    coef_d.acc[4] = '0;
    coef_d.acc[5] = '0;
    coef_d.jrk[0] = 48'sd6 * c3_q;
    coef_d.jrk[1] = 48'sd24 * c4_q;
    coef_d.jrk[2] = 48'sd60 * c5_q;
    coef_d.jrk[3] = '0;
    coef_d.jrk[4] = '0;
    coef_d.jrk[5] = '0;
  end

  // The user must keep configuration static while items are in flight (not enforced).
  always_ff @(posedge clk_i) begin
    pv0_q  <= pv0_d;
    pv1_q  <= pv1_d;
    pa0_q  <= pa0_d;
    pa1_q  <= pa1_d;
    v0_q   <= sat32(64'(pv0_q >>> FRAC_W));
    v1_q   <= sat32(64'(pv1_q >>> FRAC_W));
    ah0_q  <= sat32(64'(pa0_q >>> FRAC_W));
    ah1_q  <= sat32(64'(pa1_q >>> FRAC_W));
    pb0_q  <= pb0_d;
    pb1_q  <= pb1_d;
    a0_q   <= sat32(64'(pb0_q >>> FRAC_W));
    a1_q   <= sat32(64'(pb1_q >>> FRAC_W));
    c1_q   <= c1_d;
    c2_q   <= c2_d;
    c3_q   <= c3_d;
    c4_q   <= c4_d;
    c5_q   <= c5_d;
    coef_q <= coef_d;
  end

  assign coef_o = coef_q;

endmodule

### design/pmle_sdiv.sv
// Pipelined signed division r * 2^16 / d, truncated toward zero and clipped to +-2^44.
module pmle_sdiv (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [31:0]   d_i,
  input  pmle_pkg::acc_t r_i,
  output pmle_pkg::acc_t r_o
);
  import pmle_pkg::*;

  localparam logic [MAG_W-1:0] CLIP_MAG = {1'b1, {(MAG_W-1){1'b0}}};

  acc_t             ab;
  logic [MAG_W-1:0] mag;
  logic [FRAC_W-1:0] hi;
  logic [31:0]      rem_q [DIV_STEPS+1];
  logic [MAG_W-1:0] num_q [DIV_STEPS+1];
  logic [MAG_W-1:0] quo_q [DIV_STEPS+1];
  logic             neg_q [DIV_STEPS+1];
  logic             ovf_q [DIV_STEPS+1];
  logic [32:0]      rem2  [DIV_STEPS];
  logic             ge    [DIV_STEPS];
  logic [MAG_W-1:0] qm;
  acc_t             qs;
  acc_t             r_q;

  assign ab  = r_i[ACC_W-1] ? -r_i : r_i;
  assign mag = ab[MAG_W-1:0];
  // The top bits of the shifted numerator form the first partial remainder.
  assign hi  = mag[MAG_W-1:MAG_W-FRAC_W];

  always_comb begin
    for (int i = 0; i < DIV_STEPS; i++) begin
      rem2[i] = {rem_q[i], num_q[i][MAG_W-1]};
      ge[i]   = rem2[i] >= {1'b0, d_i};
    end
  end

  // A quotient that needs more than MAG_W bits is caught up front as an overflow.
  assign qm = ovf_q[DIV_STEPS] ? CLIP_MAG :
              (quo_q[DIV_STEPS] > CLIP_MAG) ? CLIP_MAG : quo_q[DIV_STEPS];
  assign qs = $signed({{(ACC_W-MAG_W){1'b0}}, qm});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0] <= r_i[ACC_W-1];
      ovf_q[0] <= {{(32-FRAC_W){1'b0}}, hi} >= d_i;
      rem_q[0] <= {{(32-FRAC_W){1'b0}}, hi};
      num_q[0] <= {mag[MAG_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
      quo_q[0] <= '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
        neg_q[i+1] <= neg_q[i];
        ovf_q[i+1] <= ovf_q[i];
        rem_q[i+1] <= ge[i] ? 32'(rem2[i] - {1'b0, d_i}) : rem2[i][31:0];
        num_q[i+1] <= {num_q[i][MAG_W-2:0], 1'b0};
        quo_q[i+1] <= {quo_q[i][MAG_W-2:0], ge[i]};
      end
      r_q <= neg_q[DIV_STEPS] ? -qs : qs;
    end
  end

  assign r_o = r_q;

endmodule
